// ===== rtl/core/deqp_pkg.sv =====
// Package for the pair deque: request and response beat types and the command and status codes.
`default_nettype none

package deqp_pkg;

	// Operation codes carried in a request beat.
	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
	localparam logic [1:0] CMD_POP_BACK   = 2'd3;

	// Status codes carried in a response beat.
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam int unsigned OCC_W = 7;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] first_value;
		logic signed [31:0] second_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_first;
		logic signed [31:0] popped_second;
		logic [OCC_W-1:0]   occupancy;
	} rsp_t;

	// One stored pair, first integer in the upper half.
	typedef struct packed {
		logic signed [31:0] first_value;
		logic signed [31:0] second_value;
	} pair_t;

endpackage

`default_nettype wire

// ===== rtl/core/deqp_store.sv =====
// Pair store of the deque: one write port and one registered read port.
`default_nettype none

module deqp_store #(
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = 6
) (
	input  wire                   clk,
	input  wire                   we,
	input  wire  [ADDR_W-1:0]     waddr,
	input  deqp_pkg::pair_t       wdata,
	input  wire                   re,
	input  wire  [ADDR_W-1:0]     raddr,
	output deqp_pkg::pair_t       rdata
);
	import deqp_pkg::*;

	pair_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the output holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue_of_pairs.sv =====
// Top level of the bounded double-ended queue of integer pairs.
//
// A request beat is taken at a rising edge where start is high and busy is
// low; req carries the command and, for pushes, the pair. busy stays low, so
// a request may be issued in every cycle.
// Each request gives one response beat on rsp, marked by done for exactly one
// cycle, in the cycle after the request was taken, at a throughput of one
// request per cycle. The receiver cannot stall; a response is gone after its
// cycle.
// The pairs live in a synchronous store with a registered read port. The
// index and count are updated at the accepting edge, a push writes its entry
// at that edge and a pop reads its entry at that edge, so back-to-back
// accesses to the same entry are ordered by the store itself.
// A push into a full queue reports full, a pop from an empty queue reports
// empty; neither changes anything. occupancy is the count after the request,
// low seven bits only.
// Reset clears the front index and the count at once; the store itself is
// not cleared, as no entry is read before a push has written it.
`default_nettype none

module double_ended_queue_of_pairs #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  deqp_pkg::req_t  req,
	output logic            done,
	output deqp_pkg::rsp_t  rsp
);
	import deqp_pkg::*;

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             is_push;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [SUM_W-1:0] back_sum;
	logic [SUM_W-1:0] last_sum;
	logic [IDX_W-1:0] back_slot;
	logic [IDX_W-1:0] last_slot;
	logic             push_ok;
	logic             pop_ok;
	logic [IDX_W-1:0] wr_slot;
	logic [IDX_W-1:0] rd_slot;
	logic [1:0]       status_c;
	pair_t            wr_pair;
	pair_t            rd_pair;

	logic             done_s1;
	logic             pop_ok_s1;
	logic [1:0]       status_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Decode the request against the current fill level.
	assign is_push = (req.cmd == CMD_PUSH_FRONT) || (req.cmd == CMD_PUSH_BACK);
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign push_ok = accept && is_push && !full;
	assign pop_ok  = accept && !is_push && !empty;

	// Circular index arithmetic; every sum stays below twice the capacity while the queue is not empty.
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
	assign back_sum  = SUM_W'(front_q) + SUM_W'(cnt_q);
	assign last_sum  = back_sum - 1'b1;
	assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
		IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);
	assign last_slot = (last_sum >= SUM_W'(CAPACITY)) ?
		IDX_W'(last_sum - SUM_W'(CAPACITY)) : IDX_W'(last_sum);

	// Entry touched by the request.
	assign wr_slot = (req.cmd == CMD_PUSH_FRONT) ? front_dec : back_slot;
	assign rd_slot = (req.cmd == CMD_POP_FRONT) ? front_q : last_slot;
	assign wr_pair = '{first_value: req.first_value, second_value: req.second_value};

	// Status of the request.
	always_comb begin
		case (req.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: status_c = full ? STATUS_FULL : STATUS_DONE;
			CMD_POP_FRONT, CMD_POP_BACK:   status_c = empty ? STATUS_EMPTY : STATUS_DONE;
			default:                       status_c = STATUS_DONE;
		endcase
	end

	deqp_store #(
		.DEPTH  (CAPACITY),
		.ADDR_W (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (push_ok),
		.waddr (wr_slot),
		.wdata (wr_pair),
		.re    (pop_ok),
		.raddr (rd_slot),
		.rdata (rd_pair)
	);

	// Front index and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (push_ok) begin
				cnt_q <= cnt_q + 1'b1;
				if (req.cmd == CMD_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end else if (pop_ok) begin
				cnt_q <= cnt_q - 1'b1;
				if (req.cmd == CMD_POP_FRONT) begin
					front_q <= front_inc;
				end
			end
		end
	end

	// Response stage: control under reset, status as payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1   <= 1'b0;
			pop_ok_s1 <= 1'b0;
		end else begin
			done_s1   <= accept;
			pop_ok_s1 <= pop_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
		end
	end

	// The store output carries the popped pair in the response cycle.
	assign done              = done_s1;
	assign rsp.status        = status_s1;
	assign rsp.popped_first  = pop_ok_s1 ? rd_pair.first_value : '0;
	assign rsp.popped_second = pop_ok_s1 ? rd_pair.second_value : '0;
	assign rsp.occupancy     = OCC_W'(cnt_q);

	// Every taken request gives exactly one response in the next cycle.
	a_one_response: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without a response");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("response without a request");

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A refused request leaves the count as it was.
	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_s1 != STATUS_DONE)) |-> (cnt_q == $past(cnt_q)))
		else $error("refused request changed the count");

	// An empty refusal means nothing was held.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_s1 == STATUS_EMPTY)) |-> (cnt_q == '0))
		else $error("empty status with entries held");

endmodule

`default_nettype wire

// ===== tb/sv/tb_double_ended_queue_of_pairs.sv =====
// Self-checking testbench for the pair deque: directed corner cases, then biased random traffic.
`default_nettype none

module tb_double_ended_queue_of_pairs;
	import deqp_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned RANDOM_BEATS = 1130;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	int unsigned burst_left;

	double_ended_queue_of_pairs #(
		.CAPACITY(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// Mirror of the deque contents, and the responses it says are still to come.
	class deque_mirror;
		pair_t       slots[DEPTH];
		int unsigned head;
		int unsigned held;
		int unsigned errors;
		rsp_t        awaited[$];

		function new();
			head = 0;
			held = 0;
			errors = 0;
		endfunction

		// Apply one accepted request beat and queue the response it must give.
		function void note_request(req_t r);
			rsp_t        e;
			int unsigned slot;
			e = '0;
			e.status = STATUS_DONE;
			if (r.cmd == CMD_PUSH_FRONT || r.cmd == CMD_PUSH_BACK) begin
				if (held >= DEPTH) begin
					e.status = STATUS_FULL;
				end else begin
					if (r.cmd == CMD_PUSH_FRONT) begin
						head = (head + DEPTH - 1) % DEPTH;
						slot = head;
					end else begin
						slot = (head + held) % DEPTH;
					end
					slots[slot].first_value = r.first_value;
					slots[slot].second_value = r.second_value;
					held++;
				end
			end else begin
				if (held == 0) begin
					e.status = STATUS_EMPTY;
				end else begin
					if (r.cmd == CMD_POP_FRONT) begin
						slot = head;
						head = (head + 1) % DEPTH;
					end else begin
						slot = (head + held - 1) % DEPTH;
					end
					e.popped_first = slots[slot].first_value;
					e.popped_second = slots[slot].second_value;
					held--;
				end
			end
			e.occupancy = OCC_W'(held);
			awaited.insert(awaited.size(), e);
		endfunction

		// Compare one response beat with the oldest outstanding expectation.
		function void check_response(rsp_t got);
			rsp_t e;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response: status %0d first %0d second %0d occ %0d",
						got.status, got.popped_first, got.popped_second, got.occupancy);
				return;
			end
			e = awaited[0];
			awaited.delete(0);
			if (got.status != e.status || got.popped_first != e.popped_first ||
					got.popped_second != e.popped_second || got.occupancy != e.occupancy) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						e.status, e.popped_first, e.popped_second, e.occupancy,
						got.status, got.popped_first, got.popped_second, got.occupancy);
			end
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction
	endclass

	deque_mirror mirror = new();

	// Clock with a period of four units.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Observe both sides at every edge: note the accepted request first, then check the response.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			mirror.note_request(req);
		if (arst_n && done)
			mirror.check_response(rsp);
	end

	// Operand values with a strong bias towards the signed extremes, zero and minus one.
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sh0000_0000;
			3: return -32'sd1;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic signed [31:0] a,
			logic signed [31:0] b);
		req_t r;
		r.cmd = op;
		r.first_value = a;
		r.second_value = b;
		return r;
	endfunction

	// Present one request beat and hold it until the deque takes it.
	task automatic send_request(req_t r);
		req <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Send a beat within the current burst, opening a new burst after a gap when it runs out.
	task automatic issue(req_t r);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		send_request(r);
	endtask

	// Reset, directed corners, random phases, then drain.
	initial begin
		int unsigned sent;
		int unsigned seg_len;
		int unsigned push_pct;
		logic [1:0]  op;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pops from an empty deque, extreme operands, pops down to the last entry from
		// either end, and pops whose operands carry noise.
		issue(make_req(CMD_POP_FRONT, 32'sh7fff_ffff, -32'sd1));
		issue(make_req(CMD_POP_BACK, 32'sh8000_0000, 32'sd0));
		issue(make_req(CMD_PUSH_BACK, 32'sh7fff_ffff, 32'sh8000_0000));
		issue(make_req(CMD_PUSH_FRONT, 32'sh8000_0000, 32'sh7fff_ffff));
		issue(make_req(CMD_PUSH_BACK, 32'sd0, -32'sd1));
		issue(make_req(CMD_PUSH_FRONT, -32'sd1, 32'sd0));
		issue(make_req(CMD_POP_FRONT, pick_word(), pick_word()));
		issue(make_req(CMD_POP_BACK, pick_word(), pick_word()));
		issue(make_req(CMD_POP_FRONT, pick_word(), pick_word()));
		issue(make_req(CMD_POP_BACK, pick_word(), pick_word()));
		issue(make_req(CMD_POP_BACK, -32'sd1, -32'sd1));
		issue(make_req(CMD_PUSH_FRONT, 32'sd1, 32'sd2));
		issue(make_req(CMD_POP_FRONT, 32'sd0, 32'sd0));
		issue(make_req(CMD_POP_FRONT, 32'sd0, 32'sd0));
		issue(make_req(CMD_PUSH_BACK, 32'sh1234_5678, -32'sh1234_5678));
		issue(make_req(CMD_POP_BACK, 32'sd0, 32'sd0));
		issue(make_req(CMD_PUSH_FRONT, 32'sh5555_5555, 32'shaaaa_aaaa));
		issue(make_req(CMD_PUSH_FRONT, 32'shaaaa_aaaa, 32'sh5555_5555));
		issue(make_req(CMD_POP_BACK, 32'sh7fff_ffff, 32'sh7fff_ffff));
		issue(make_req(CMD_POP_FRONT, 32'sh8000_0000, 32'sh8000_0000));

		// Phases with different push shares, so the deque fills, overflows, drains and
		// wraps its head index round the store many times.
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			case ($urandom_range(0, 6))
				0: push_pct = 90;
				1: push_pct = 10;
				2: push_pct = 50;
				3: push_pct = 75;
				4: push_pct = 25;
				5: push_pct = 97;
				default: push_pct = 3;
			endcase
			seg_len = $urandom_range(40, 150);
			// The last phase stops at the planned number of beats.
			if (seg_len > RANDOM_BEATS - sent)
				seg_len = RANDOM_BEATS - sent;
			repeat (seg_len) begin
				if ($urandom_range(0, 99) < push_pct)
					op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
				else
					op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
				issue(make_req(op, pick_word(), pick_word()));
				sent++;
			end
		end
		start <= 1'b0;

		// Wait for the last responses, then for any stray response.
		while (mirror.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mirror.errors == 0)
			$display("tb_double_ended_queue_of_pairs: clean");
		else
			$display("tb_double_ended_queue_of_pairs: errors");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("tb_double_ended_queue_of_pairs: errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/deqp_pkg.sv
rtl/core/deqp_store.sv
rtl/core/double_ended_queue_of_pairs.sv
tb/sv/tb_double_ended_queue_of_pairs.sv
